### src/bbrt_pkg.sv
package bbrt_pkg;

  // Map geometry. These fix the widths of the block and count fields of the request and response.
  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned MAP_AW     = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Field widths.
  localparam int unsigned OFF_W   = 34;
  localparam int unsigned LEN_W   = 25;
  localparam int unsigned CAP_W   = 35;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned BOFF_W  = 24;
  localparam int unsigned BSZ_W   = 25;

  // Erase block size limits, as log2 of bytes.
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd9;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd24;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd17;

  typedef enum logic [1:0] {
    OP_SCAN    = 2'd0,
    OP_XLATE   = 2'd1,
    OP_ATTEMPT = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_RANGE   = 3'd1,
    STAT_RETRY   = 3'd2,
    STAT_RETIRED = 3'd3,
    STAT_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_XLATE,
    S_SHIFT
  } state_e;

  typedef struct packed {
    opcode_e              opcode;
    logic                 block_bad;
    logic [OFF_W-1:0]     byte_offset;
    logic [LEN_W-1:0]     byte_length;
    logic [MAP_AW-1:0]    logical_block;
    logic                 attempt_failed;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0]     physical_address;
    logic [LEN_W-1:0]     chunk_length;
    status_e              status;
    logic [CNT_W-1:0]     good_blocks;
    logic [CAP_W-1:0]     capacity_bytes;
  } rsp_t;

endpackage

### src/bbrt_if.sv
interface bbrt_req_if;
  import bbrt_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bbrt_rsp_if;
  import bbrt_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/flash_bad_block_remap_table_core.sv
// Bad-block skipping map for a NAND partition. The logical-to-physical block
// map sits in one synchronous memory of 1024 entries; only entries below the
// good block count are ever read, so the memory needs no clearing after reset.
// Each request gives exactly one response, held in an output register. Scan,
// write attempt and clear requests, and translates outside the map, load the
// response register when taken. A translate that hits the map answers from
// the S_XLATE state, since the physical block number comes from the map
// memory's registered read. A write attempt that retires a block answers at
// once and then keeps the request side busy while the later map entries move
// down one place, one entry per cycle through the memory's read and write
// ports. A request is taken when the block is idle and the output register
// is empty or being drained. The user must write the block size register
// only while no request is in flight; the block does not enforce this.
// Values below 9 count as 9 and values above 24 count as 24.
module flash_bad_block_remap_table_core #(
  parameter int unsigned RETRY_LIMIT = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bbrt_pkg::SHIFT_W-1:0] cfg_wdata_i,
  bbrt_req_if.sink                     req_i,
  bbrt_rsp_if.source                   rsp_o
);
  import bbrt_pkg::*;

  localparam int unsigned RUN_W = $clog2(RETRY_LIMIT + 1);

  state_e state_q, state_d;

  logic [SHIFT_W-1:0] shift_q;
  logic [CNT_W-1:0]   good_q, good_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic [RUN_W-1:0]   run_q, run_d, run_next;
  logic [MAP_AW-1:0]  fail_q, fail_d;
  logic [MAP_AW-1:0]  ptr_q, ptr_d;
  logic               wr_pend_q, wr_pend_d;
  logic [MAP_AW-1:0]  wr_addr_q, wr_addr_d;
  logic [BOFF_W-1:0]  boff_q, boff_d;
  logic [LEN_W-1:0]   chunk_q, chunk_d;
  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic [MAP_AW-1:0]  map_mem [MAX_BLOCKS];
  logic [MAP_AW-1:0]  rd_data_q;
  logic               mem_we, mem_re;
  logic [MAP_AW-1:0]  mem_waddr, mem_raddr, mem_wdata;

  logic               accept;
  logic               attempt_ok;
  logic               retire;
  logic               xlate_hit;
  logic               in_range;
  logic [MAP_AW-1:0]  map_idx;
  logic [BOFF_W-1:0]  blk_off;
  logic [LEN_W-1:0]   chunk;
  logic [OFF_W-1:0]   paddr;
  logic [CAP_W-1:0]   capacity;

  bbrt_addr_calc u_calc (
    .shift_i       (shift_q),
    .byte_offset_i (req_i.data.byte_offset),
    .byte_length_i (req_i.data.byte_length),
    .good_count_i  (good_q),
    .cap_count_i   (good_d),
    .map_entry_i   (rd_data_q),
    .entry_off_i   (boff_q),
    .in_range_o    (in_range),
    .map_idx_o     (map_idx),
    .blk_off_o     (blk_off),
    .chunk_o       (chunk),
    .paddr_o       (paddr),
    .capacity_o    (capacity)
  );

  // Request decode shared by the state machine and the datapath.
  assign req_i.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign attempt_ok  = CNT_W'(req_i.data.logical_block) < good_q;
  assign run_next    = ((run_q == '0) || (req_i.data.logical_block != fail_q)) ?
                       RUN_W'(1) : run_q + RUN_W'(1);
  assign retire      = accept && (req_i.data.opcode == OP_ATTEMPT) && attempt_ok &&
                       req_i.data.attempt_failed && (run_next >= RUN_W'(RETRY_LIMIT));
  assign xlate_hit   = accept && (req_i.data.opcode == OP_XLATE) && in_range;

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (xlate_hit) begin
          state_d = S_XLATE;
        end else if (retire) begin
          state_d = S_SHIFT;
        end
      end
      S_XLATE: begin
        state_d = S_IDLE;
      end
      S_SHIFT: begin
        if (CNT_W'(ptr_q) >= good_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath, memory ports and response register loading.
  always_comb begin
    good_d      = good_q;
    scan_d      = scan_q;
    run_d       = run_q;
    fail_d      = fail_q;
    ptr_d       = ptr_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    boff_d      = boff_q;
    chunk_d     = chunk_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_q;
    mem_wdata   = rd_data_q;
    mem_re      = 1'b0;
    mem_raddr   = map_idx;

    // A shifted entry read last cycle is written one place lower.
    if (wr_pend_q) begin
      mem_we = 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.physical_address = '0;
          rsp_d.chunk_length     = '0;
          rsp_d.status           = STAT_OK;
          case (req_i.data.opcode)
            OP_SCAN: begin
              if (scan_q >= CNT_W'(MAX_BLOCKS)) begin
                rsp_d.status = STAT_FULL;
              end else begin
                if (!req_i.data.block_bad && (good_q < CNT_W'(MAX_BLOCKS))) begin
                  mem_we    = 1'b1;
                  mem_waddr = good_q[MAP_AW-1:0];
                  mem_wdata = scan_q[MAP_AW-1:0];
                  good_d    = good_q + CNT_W'(1);
                end
                scan_d = scan_q + CNT_W'(1);
              end
            end
            OP_XLATE: begin
              boff_d  = blk_off;
              chunk_d = chunk;
              if (in_range) begin
                mem_re = 1'b1;
              end else begin
                rsp_d.status = STAT_RANGE;
              end
            end
            OP_ATTEMPT: begin
              if (!attempt_ok) begin
                rsp_d.status = STAT_RANGE;
              end else if (!req_i.data.attempt_failed) begin
                run_d = '0;
              end else begin
                fail_d = req_i.data.logical_block;
                if (retire) begin
                  run_d        = '0;
                  good_d       = good_q - CNT_W'(1);
                  ptr_d        = req_i.data.logical_block;
                  rsp_d.status = STAT_RETIRED;
                end else begin
                  run_d        = run_next;
                  rsp_d.status = STAT_RETRY;
                end
              end
            end
            OP_CLEAR: begin
              good_d = '0;
              scan_d = '0;
              run_d  = '0;
              fail_d = '0;
            end
            default: begin
              rsp_d.status = STAT_OK;
            end
          endcase
          rsp_d.good_blocks    = good_d;
          rsp_d.capacity_bytes = capacity;
          // A translate that hits the map answers next cycle instead.
          rsp_valid_d = !xlate_hit;
        end
      end
      S_XLATE: begin
        rsp_d.physical_address = paddr;
        rsp_d.chunk_length     = chunk_q;
        rsp_d.status           = STAT_OK;
        rsp_d.good_blocks      = good_q;
        rsp_d.capacity_bytes   = capacity;
        rsp_valid_d            = 1'b1;
      end
      S_SHIFT: begin
        // Read the entry above the current slot; it lands there next cycle.
        if (CNT_W'(ptr_q) < good_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + MAP_AW'(1);
          wr_pend_d = 1'b1;
          wr_addr_d = ptr_q;
          ptr_d     = ptr_q + MAP_AW'(1);
        end
      end
      default: begin
        wr_pend_d = 1'b0;
      end
    endcase
  end

  // Block map memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= map_mem[mem_raddr];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      shift_q     <= SHIFT_RST;
      good_q      <= '0;
      scan_q      <= '0;
      run_q       <= '0;
      fail_q      <= '0;
      ptr_q       <= '0;
      wr_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      good_q      <= good_d;
      scan_q      <= scan_d;
      run_q       <= run_d;
      fail_q      <= fail_d;
      ptr_q       <= ptr_d;
      wr_pend_q   <= wr_pend_d;
      rsp_valid_q <= rsp_valid_d;
      // The block size is held inside its legal range when written.
      if (cfg_we_i) begin
        if (cfg_wdata_i < SHIFT_MIN) begin
          shift_q <= SHIFT_MIN;
        end else if (cfg_wdata_i > SHIFT_MAX) begin
          shift_q <= SHIFT_MAX;
        end else begin
          shift_q <= cfg_wdata_i;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    boff_q    <= boff_d;
    chunk_q   <= chunk_d;
    rsp_q     <= rsp_d;
  end

endmodule

### src/bbrt_addr_calc.sv
module bbrt_addr_calc (
  input  logic [bbrt_pkg::SHIFT_W-1:0] shift_i,
  input  logic [bbrt_pkg::OFF_W-1:0]   byte_offset_i,
  input  logic [bbrt_pkg::LEN_W-1:0]   byte_length_i,
  input  logic [bbrt_pkg::CNT_W-1:0]   good_count_i,
  input  logic [bbrt_pkg::CNT_W-1:0]   cap_count_i,
  input  logic [bbrt_pkg::MAP_AW-1:0]  map_entry_i,
  input  logic [bbrt_pkg::BOFF_W-1:0]  entry_off_i,
  output logic                         in_range_o,
  output logic [bbrt_pkg::MAP_AW-1:0]  map_idx_o,
  output logic [bbrt_pkg::BOFF_W-1:0]  blk_off_o,
  output logic [bbrt_pkg::LEN_W-1:0]   chunk_o,
  output logic [bbrt_pkg::OFF_W-1:0]   paddr_o,
  output logic [bbrt_pkg::CAP_W-1:0]   capacity_o
);
  import bbrt_pkg::*;

  logic [OFF_W-1:0] blk_idx;
  logic [BSZ_W-1:0] blk_bytes;
  logic [BSZ_W-1:0] blk_mask;
  logic [BSZ_W-1:0] room;

  // Split the logical offset into a block index and an offset inside the block.
  assign blk_idx    = byte_offset_i >> shift_i;
  assign in_range_o = blk_idx < OFF_W'(good_count_i);
  assign map_idx_o  = blk_idx[MAP_AW-1:0];
  assign blk_bytes  = BSZ_W'(1) << shift_i;
  assign blk_mask   = blk_bytes - BSZ_W'(1);
  assign blk_off_o  = byte_offset_i[BOFF_W-1:0] & blk_mask[BOFF_W-1:0];

  // The chunk stops at the block end or when the wanted length runs out.
  assign room    = blk_bytes - BSZ_W'(blk_off_o);
  assign chunk_o = (room < byte_length_i) ? room : byte_length_i;

  // Physical address from the mapped block and the registered block offset.
  assign paddr_o = (OFF_W'(map_entry_i) << shift_i) | OFF_W'(entry_off_i);

  assign capacity_o = CAP_W'(cap_count_i) << shift_i;

endmodule

### test/tb_flash_bad_block_remap_table_core.sv
`timescale 1ns / 1ps

module tb_flash_bad_block_remap_table_core;
  import bbrt_pkg::*;

  localparam int unsigned RETRIES      = 4;
  // A retire moves up to MAX_BLOCKS - 1 map entries after its response is loaded.
  localparam int unsigned SHIFT_SETTLE = MAX_BLOCKS + 76;
  localparam int unsigned LONG_HOLD    = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [SHIFT_W-1:0] cfg_wdata_i;

  bbrt_req_if req_if ();
  bbrt_rsp_if rsp_if ();

  flash_bad_block_remap_table_core #(
    .RETRY_LIMIT(RETRIES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Our own copy of the map state and the block size register.
  logic [MAP_AW-1:0]  map_copy [MAX_BLOCKS];
  int unsigned        good_cnt  = 0;
  int unsigned        scan_pos  = 0;
  int unsigned        fail_run  = 0;
  logic [MAP_AW-1:0]  fail_blk  = '0;
  logic [SHIFT_W-1:0] shift_cfg = SHIFT_RST;

  req_t requests_waiting[$];
  rsp_t answers_due[$];
  int   err_count   = 0;
  int   reqs_made   = 0;
  int   burst_left  = 0;
  int   gap_left    = 0;
  int   holds_asked = 0;
  int   holds_done  = 0;
  int   hold_left   = 0;
  int   stall_tick  = 0;
  logic [7:0] stall_pat = 8'hFF;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Block size in use: the register held within its legal range.
  function automatic int unsigned eff_shift(logic [SHIFT_W-1:0] v);
    if (v < SHIFT_MIN) return SHIFT_MIN;
    if (v > SHIFT_MAX) return SHIFT_MAX;
    return v;
  endfunction

  // Works out the response to one request and advances the map state.
  function automatic rsp_t next_remap_answer(req_t q);
    int unsigned sh;
    int unsigned i;
    logic [63:0] bsize, idx, boff, room, len;
    rsp_t        a;
    sh     = eff_shift(shift_cfg);
    bsize  = 64'd1 << sh;
    a      = '0;
    a.status = STAT_OK;
    case (q.opcode)
      OP_SCAN: begin
        if (scan_pos >= MAX_BLOCKS) begin
          a.status = STAT_FULL;
        end else begin
          if (!q.block_bad && good_cnt < MAX_BLOCKS) begin
            map_copy[good_cnt] = MAP_AW'(scan_pos);
            good_cnt++;
          end
          scan_pos++;
        end
      end
      OP_XLATE: begin
        idx  = 64'(q.byte_offset) >> sh;
        boff = 64'(q.byte_offset) & (bsize - 64'd1);
        if (idx >= good_cnt) begin
          a.status = STAT_RANGE;
        end else begin
          room = bsize - boff;
          len  = 64'(q.byte_length);
          a.physical_address = OFF_W'((64'(map_copy[idx[MAP_AW-1:0]]) << sh) | boff);
          a.chunk_length     = LEN_W'((room < len) ? room : len);
        end
      end
      OP_ATTEMPT: begin
        if (q.logical_block >= good_cnt) begin
          a.status = STAT_RANGE;
        end else if (!q.attempt_failed) begin
          fail_run = 0;
        end else begin
          if (fail_run == 0 || q.logical_block != fail_blk) begin
            fail_blk = q.logical_block;
            fail_run = 1;
          end else begin
            fail_run++;
          end
          if (fail_run >= RETRIES) begin
            // Retire the entry: later entries move down one place.
            for (i = q.logical_block; i + 1 < good_cnt; i++) begin
              map_copy[i] = map_copy[i+1];
            end
            good_cnt--;
            fail_run = 0;
            a.status = STAT_RETIRED;
          end else begin
            a.status = STAT_RETRY;
          end
        end
      end
      OP_CLEAR: begin
        good_cnt = 0;
        scan_pos = 0;
        fail_run = 0;
        fail_blk = '0;
      end
      default: begin
        a.status = STAT_OK;
      end
    endcase
    a.good_blocks    = CNT_W'(good_cnt);
    a.capacity_bytes = CAP_W'(64'(good_cnt) << sh);
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A request with every field random, then the opcode forced.
  function automatic req_t rand_req(opcode_e op);
    logic [95:0] bits;
    req_t        r;
    bits     = {$urandom, $urandom, $urandom};
    r        = req_t'(bits[$bits(req_t)-1:0]);
    r.opcode = op;
    return r;
  endfunction

  // Keep the pending queue short so that the state used for aiming is recent.
  task automatic push_req(req_t r);
    while (requests_waiting.size() >= 2) @(negedge clk_i);
    requests_waiting.push_back(r);
    reqs_made++;
  endtask

  task automatic send_scan(logic bad);
    req_t r;
    r           = rand_req(OP_SCAN);
    r.block_bad = bad;
    push_req(r);
  endtask

  task automatic send_xlate(logic [OFF_W-1:0] off, logic [LEN_W-1:0] len);
    req_t r;
    r             = rand_req(OP_XLATE);
    r.byte_offset = off;
    r.byte_length = len;
    push_req(r);
  endtask

  task automatic send_attempt(logic [MAP_AW-1:0] blk, logic failed);
    req_t r;
    r                = rand_req(OP_ATTEMPT);
    r.logical_block  = blk;
    r.attempt_failed = failed;
    push_req(r);
  endtask

  task automatic send_clear();
    push_req(rand_req(OP_CLEAR));
  endtask

  // Wait until nothing is queued, offered or outstanding.
  task automatic drain();
    while (requests_waiting.size() != 0 || req_if.valid || answers_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Register writes happen only with the block idle, after any map shift.
  task automatic write_block_shift(logic [SHIFT_W-1:0] v);
    drain();
    repeat (SHIFT_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shift_cfg   = v;
    @(negedge clk_i);
  endtask

  // Translates mostly aimed inside the map, at block edges and lengths near the size.
  task automatic random_xlate();
    int unsigned       sh;
    logic [63:0]       bsize, boff, off, len;
    logic [MAP_AW-1:0] lb;
    sh    = eff_shift(shift_cfg);
    bsize = 64'd1 << sh;
    off   = rand64();
    case ($urandom_range(0, 3))
      0: boff = 64'd0;
      1: boff = bsize - 64'd1;
      2: boff = bsize - 64'($urandom_range(1, 64));
      default: boff = rand64() & (bsize - 64'd1);
    endcase
    case ($urandom_range(0, 9))
      0: off = rand64();
      1: off = (64'(good_cnt) << sh) | boff;
      default: begin
        if (good_cnt > 0) begin
          lb  = MAP_AW'($urandom_range(0, good_cnt - 1));
          off = (64'(lb) << sh) | boff;
        end
      end
    endcase
    case ($urandom_range(0, 5))
      0: len = 64'($urandom_range(0, 3));
      1: len = 64'((1 << LEN_W) - 1);
      2: len = bsize + 64'($urandom_range(0, 4)) - 64'd2;
      3: len = 64'($urandom_range(1, 65536));
      default: len = rand64();
    endcase
    send_xlate(OFF_W'(off), LEN_W'(len));
  endtask

  // A run of write failures on one block, now and then broken up.
  task automatic random_attempts();
    logic [MAP_AW-1:0] lb;
    int                n;
    lb = MAP_AW'($urandom);
    if (good_cnt > 0 && $urandom_range(0, 7) != 0) lb = MAP_AW'($urandom_range(0, good_cnt - 1));
    n = $urandom_range(1, 5);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: send_attempt(lb, 1'b0);
        1: send_attempt(MAP_AW'($urandom), 1'b1);
        default: send_attempt(lb, 1'b1);
      endcase
    end
  endtask

  task automatic random_traffic(int count);
    int stop_at;
    int w;
    stop_at = reqs_made + count;
    while (reqs_made < stop_at) begin
      w = $urandom_range(0, 99);
      if (w < 25) begin
        repeat ($urandom_range(1, 24)) send_scan($urandom_range(0, 4) == 0);
      end else if (w < 55) begin
        random_xlate();
      end else if (w < 82) begin
        random_attempts();
      end else if (w < 84) begin
        send_clear();
        repeat ($urandom_range(10, 60)) send_scan($urandom_range(0, 4) == 0);
      end else begin
        // Noise: any operation but clear, all fields random.
        push_req(rand_req(opcode_e'($urandom_range(0, 2))));
      end
    end
  endtask

  // Sender: bursts of random length with random gaps in between.
  always @(posedge clk_i) begin
    logic offer;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      offer = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        answers_due.push_back(next_remap_answer(req_if.data));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_waiting.size() > 0) begin
          req_if.data <= requests_waiting.pop_front();
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      req_if.valid <= offer;
    end
  end

  // Receiver: a random stall pattern, redrawn periodically, plus long hold-offs on demand.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = LONG_HOLD - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      if (stall_tick % 64 == 0) begin
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h11);
      end
      rsp_if.ready <= stall_pat[stall_tick % 8];
      stall_tick++;
    end
  end

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Compare each response with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (answers_due.size() == 0) begin
        err_count++;
        $display("%0t: unexpected response, expected none, actual status %0d", $time,
                 rsp_if.data.status);
      end else begin
        want = answers_due.pop_front();
        check_field("physical_address", 64'(want.physical_address),
                    64'(rsp_if.data.physical_address));
        check_field("chunk_length", 64'(want.chunk_length), 64'(rsp_if.data.chunk_length));
        check_field("status", 64'(want.status), 64'(rsp_if.data.status));
        check_field("good_blocks", 64'(want.good_blocks), 64'(rsp_if.data.good_blocks));
        check_field("capacity_bytes", 64'(want.capacity_bytes),
                    64'(rsp_if.data.capacity_bytes));
      end
    end
  end

  initial begin
    logic [63:0] bs;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset block size: physical block 0 is bad, 1..4 good.
    bs = 64'd1 << SHIFT_RST;
    send_scan(1'b1);
    repeat (4) send_scan(1'b0);
    send_xlate('0, 25'd1);
    send_xlate(OFF_W'(bs - 64'd1), '1);
    send_xlate(OFF_W'(2 * bs + bs / 2), LEN_W'(bs));
    send_xlate(OFF_W'(3 * bs + 64'd5), '0);
    send_xlate(OFF_W'(4 * bs), 25'd100);
    send_xlate('1, '1);
    send_attempt('1, 1'b1);
    send_attempt(10'd1, 1'b0);
    repeat (3) send_attempt(10'd1, 1'b1);
    // Switching blocks restarts the run; four in a row retire block 2.
    repeat (4) send_attempt(10'd2, 1'b1);
    send_xlate(OFF_W'(2 * bs), 25'd16);
    send_clear();
    send_xlate('0, 25'd1);
    send_attempt('0, 1'b1);
    send_scan(1'b0);

    write_block_shift(5'd9);
    holds_asked++;
    random_traffic(60);

    // Fill the whole partition so scans run past the end.
    write_block_shift(5'd24);
    send_clear();
    repeat (MAX_BLOCKS + 6) send_scan($urandom_range(0, 9) == 0);
    random_traffic(40);

    write_block_shift(5'd0);
    random_traffic(30);

    write_block_shift(5'd31);
    holds_asked++;
    random_traffic(30);

    write_block_shift(SHIFT_W'($urandom));
    random_traffic(30);

    drain();
    repeat (SHIFT_SETTLE) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
src/bbrt_pkg.sv
src/bbrt_if.sv
src/bbrt_addr_calc.sv
src/flash_bad_block_remap_table_core.sv
test/tb_flash_bad_block_remap_table_core.sv
